// ----- rtl/core/clsa_pkg.sv -----
// clsa_pkg: shared types, sequencer states and jump-ahead rom tables
// for the combined generator skip-ahead core; no dependencies

package clsa_pkg;

	localparam int unsigned CNT_W     = 48;
	localparam int unsigned ROM_DEPTH = 48;
	localparam int unsigned ROM_AW    = 6;

	typedef struct packed {
		logic [30:0]        seed31_in;
		logic signed [31:0] seed27_in;
		logic [CNT_W-1:0]   skip_count;
	} in_word_t;

	typedef struct packed {
		logic [30:0]        seed31_out;
		logic signed [31:0] seed27_out;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULX,
		ST_MULY,
		ST_FOLDY,
		ST_DONE
	} state_t;

	// multipliers for 2^k steps modulo 2^31-1
	localparam logic [30:0] MUL31_ROM [ROM_DEPTH] = '{
		31'd16807,      31'd282475249,  31'd984943658,  31'd1457850878,
		31'd1137522503, 31'd1636807826, 31'd685118024,  31'd515204530,
		31'd897054849,  31'd2038299453, 31'd1836275591, 31'd349037107,
		31'd149796865,  31'd1186652285, 31'd2106880871, 31'd877809922,
		31'd1682791109, 31'd1900685356, 31'd2080563572, 31'd612544882,
		31'd1295048709, 31'd1987420232, 31'd868966365,  31'd1331238991,
		31'd1550655590, 31'd766698560,  31'd1154667137, 31'd901595110,
		31'd1008653149, 31'd1821072732, 31'd2147466840, 31'd282475249,
		31'd984943658,  31'd1457850878, 31'd1137522503, 31'd1636807826,
		31'd685118024,  31'd515204530,  31'd897054849,  31'd2038299453,
		31'd1836275591, 31'd349037107,  31'd149796865,  31'd1186652285,
		31'd2106880871, 31'd877809922,  31'd1682791109, 31'd1900685356
	};

	// multipliers for 2^k steps modulo 2^27+1
	localparam logic [26:0] MUL27_ROM [ROM_DEPTH] = '{
		27'd4971028,   27'd24855136,  27'd19884109,  27'd9942055,
		27'd79536433,  27'd84507460,  27'd49710271,  27'd114333622,
		27'd64623352,  27'd99420541,  27'd124275676, 27'd39768217,
		27'd94449514,  27'd69594379,  27'd109362595, 27'd54681298,
		27'd34797190,  27'd129246703, 27'd4971028,   27'd24855136,
		27'd19884109,  27'd9942055,   27'd79536433,  27'd84507460,
		27'd49710271,  27'd114333622, 27'd64623352,  27'd99420541,
		27'd124275676, 27'd39768217,  27'd94449514,  27'd69594379,
		27'd109362595, 27'd54681298,  27'd34797190,  27'd129246703,
		27'd4971028,   27'd24855136,  27'd19884109,  27'd9942055,
		27'd79536433,  27'd84507460,  27'd49710271,  27'd114333622,
		27'd64623352,  27'd99420541,  27'd124275676, 27'd39768217
	};

	// increments for 2^k steps modulo 2^27+1
	localparam logic [26:0] ADD27_ROM [ROM_DEPTH] = '{
		27'd28363543,  27'd2045789,   27'd113454172, 27'd23096237,
		27'd95902744,  27'd17819543,  27'd70436275,  27'd41452010,
		27'd13309642,  27'd46503392,  27'd97977811,  27'd111448163,
		27'd78736543,  27'd13313303,  27'd46510714,  27'd68166293,
		27'd96564370,  27'd63882038,  27'd73082779,  27'd91484261,
		27'd23895658,  27'd112414667, 27'd6104146,   27'd106657805,
		27'd113895070, 27'd128369600, 27'd52927093,  27'd125738294,
		27'd122229886, 27'd25734584,  27'd41527114,  27'd73112174,
		27'd31890727,  27'd38926319,  27'd38084422,  27'd81139871,
		27'd107598445, 27'd26297864,  27'd27740593,  27'd120104537,
		27'd21483886,  27'd3199556,   27'd41196301,  27'd117189791,
		27'd30567475,  27'd81019058,  27'd32791414,  27'd115293098
	};

endpackage

// ----- rtl/core/combined_lcg_skip_ahead_core.sv -----
// combined_lcg_skip_ahead_core: advances both seeds of a combined generator
// by a skip count, one shared 32x31 multiplier under a small sequencer
// depends on clsa_pkg
// sequence: per count bit up to the highest set one, a clear bit only shifts the count and a
// set bit runs x multiply, y multiply and y fold; the result then waits in the done state
// one word at a time: the next word is taken as soon as the sequencer idles, even while the
// previous result waits in the output register
// reset: clears the sequencer state and output valid; datapath registers are not reset

module combined_lcg_skip_ahead_core #(
	parameter int unsigned SKIP_BITS = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  clsa_pkg::in_word_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output clsa_pkg::out_word_t out_data
);
	import clsa_pkg::*;

	state_t state_q, state_d;

	logic [31:0]          x_q;
	logic [30:0]          y_q;
	logic [31:0]          raw27_q;
	logic [SKIP_BITS-1:0] n_q;
	logic [ROM_AW-1:0]    k_q;
	logic [62:0]          prod_q;
	logic                 out_valid_q;
	out_word_t            out_q;

	logic [31:0] mul_a;
	logic [30:0] mul_b;
	logic [62:0] mul_p;

	logic [32:0] fx1;
	logic [31:0] fx2;

	logic [58:0]        vy;
	logic signed [33:0] fy1;
	logic signed [33:0] fy2;

	logic in_fire;
	logic load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// shared multiplier operands
	always_comb begin
		if (state_q == ST_MULX) begin
			mul_a = x_q;
			mul_b = MUL31_ROM[k_q];
		end else begin
			mul_a = {1'b0, y_q};
			mul_b = {4'b0, MUL27_ROM[k_q]};
		end
	end

	assign mul_p = 63'(mul_a) * 63'(mul_b);

	// two folds modulo 2^31-1
	assign fx1 = {2'b0, prod_q[30:0]} + {1'b0, prod_q[62:31]};
	assign fx2 = {1'b0, fx1[30:0]} + {30'b0, fx1[32:31]};

	// add increment, then two folds modulo 2^27+1
	assign vy  = prod_q[58:0] + 59'(ADD27_ROM[k_q]);
	assign fy1 = $signed({7'b0, vy[26:0]}) - $signed({2'b0, vy[58:27]});
	assign fy2 = $signed({7'b0, fy1[26:0]}) - $signed({{27{fy1[33]}}, fy1[33:27]});

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_MULX;
			end
			ST_MULX: begin
				if (n_q == '0) state_d = ST_DONE;
				else if (n_q[0]) state_d = ST_MULY;
			end
			ST_MULY: begin
				state_d = ST_FOLDY;
			end
			ST_FOLDY: begin
				state_d = ST_MULX;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					x_q     <= {1'b0, in_data.seed31_in};
					y_q     <= in_data.seed27_in[30:0];
					raw27_q <= in_data.seed27_in;
					n_q     <= in_data.skip_count[SKIP_BITS-1:0];
					k_q     <= '0;
				end
			end
			ST_MULX: begin
				if (n_q != '0) begin
					if (n_q[0]) begin
						prod_q <= mul_p;
					end else begin
						n_q <= n_q >> 1;
						k_q <= k_q + 1'b1;
					end
				end
			end
			ST_MULY: begin
				x_q    <= fx2;
				prod_q <= mul_p;
			end
			ST_FOLDY: begin
				y_q <= fy2[30:0];
				n_q <= n_q >> 1;
				k_q <= k_q + 1'b1;
			end
			ST_DONE: begin
				if (load_out) begin
					out_q.seed31_out <= x_q[30:0];
					out_q.seed27_out <= raw27_q[31] ? raw27_q : {1'b0, y_q};
				end
			end
			default: begin
			end
		endcase
	end

	// x stays loosely reduced after its fold
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_MULY) |-> x_q <= 32'h8000_0001)
		else $error("x fold out of range");

	// y fits in 28 bits after its fold
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_FOLDY) |-> y_q[30:28] == 3'b0)
		else $error("y fold out of range");

	// each finished set bit advances the rom index by one and returns to the x multiply
	a_k_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FOLDY |=> k_q == $past(k_q) + 1'b1 && state_q == ST_MULX)
		else $error("bit index did not advance");

endmodule
